// ----- design/ngrp_pkg.sv -----
// Package for the nested group assigner: field widths, transaction layout,
// register indexes and the command/status types between controller and datapath.
// No dependencies.
package ngrp_pkg;

   // Field widths of one request and one response
   localparam int ROW_W       = 31;
   localparam int KEY_W       = 64;
   localparam int KEY_FIELDS  = 4;
   localparam int NEST_ID_W   = 7;

   // Stream layout
   localparam int REQ_TDATA_W = 288;   // row_index, key_a .. key_d, zero pad
   localparam int RSP_TDATA_W = 8;     // nest_id, zero pad
   localparam int RSP_TUSER_W = 2;     // opened_nest, table_full

   // Register port
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 3;
   localparam int CFG_COLS_W  = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_CHECK_ORDER = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_IN_USE = 1'b1;

   // Controller to datapath
   typedef struct packed {
      logic load;     // capture the incoming transaction, rewind the scan
      logic scan;     // issue the next table read
      logic decide;   // latch where the item goes
      logic commit;   // write the table and present the result
   } ngrp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic quick;      // restart flag or empty table
      logic hit;        // the entry under compare fits
      logic exhausted;  // every nest in use was compared without a fit
      logic rsp_free;   // the result register can take a new result
   } ngrp_sts_type;

endpackage

// ----- design/ngrp_ctrl.sv -----
// Controller of the nested group assigner: idle / scan / finish sequencing.
// Depends on ngrp_pkg for the command and status types.
module ngrp_ctrl import ngrp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  ngrp_sts_type sts,
   output ngrp_cmd_type cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0] state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.quick || sts.hit || sts.exhausted) begin
               cmd.decide = 1'b1;
               state_in   = ST_FINISH;
            end else begin
               cmd.scan = 1'b1;
            end
         end
         ST_FINISH: begin
            if (sts.rsp_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- design/ngrp_dpath.sv -----
// Datapath of the nested group assigner: configuration, item capture, nest table
// memory, scan pipeline, key compare, decision and result register.
// Depends on ngrp_pkg.
module ngrp_dpath import ngrp_pkg::*; #(
   parameter int MAX_NESTS = 64,
   parameter int KEY_COLS  = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ngrp_cmd_type           cmd,
   output ngrp_sts_type           sts,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic [RSP_TUSER_W-1:0] rsp_tuser,
   input  logic                   csr_valid,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int STORED_COLS = (KEY_COLS < KEY_FIELDS) ? KEY_COLS : KEY_FIELDS;
   localparam int AW    = (MAX_NESTS > 1) ? $clog2(MAX_NESTS) : 1;
   localparam int CW    = $clog2(MAX_NESTS + 1);
   localparam int IW    = (AW + 1 > NEST_ID_W) ? AW + 1 : NEST_ID_W;
   localparam int MEM_W = STORED_COLS * KEY_W + ROW_W;

   localparam logic [1:0] KIND_RESTART = 2'd0;
   localparam logic [1:0] KIND_HIT     = 2'd1;
   localparam logic [1:0] KIND_APPEND  = 2'd2;
   localparam logic [1:0] KIND_FULL    = 2'd3;

   // Configuration
   logic                  cfg_order_ff;
   logic [CFG_COLS_W-1:0] cfg_cols_ff;
   logic [CFG_COLS_W-1:0] ncmp;

   // Captured item
   logic [ROW_W-1:0]                       item_row_ff;
   logic                                   item_restart_ff;
   logic [STORED_COLS-1:0][KEY_W-1:0]      item_keys_ff;
   logic [MEM_W-1:0]                       item_word;

   // Table and scan
   logic [MEM_W-1:0] mem [MAX_NESTS];
   logic [MEM_W-1:0] rd_data_ff;
   logic [CW-1:0]    count_ff;
   logic [CW-1:0]    ptr_ff;
   logic [AW-1:0]    tag_ff;
   logic             data_vld_ff;
   logic             rd_en;
   logic             fit;

   // Decision
   logic [1:0]    dec_kind_ff, dec_kind_in;
   logic [AW-1:0] dec_addr_ff, dec_addr_in;
   logic [IW-1:0] id_wide;

   // Result register
   logic                 rsp_valid_ff;
   logic [NEST_ID_W-1:0] rsp_id_ff;
   logic                 rsp_opened_ff;
   logic                 rsp_full_ff;

   // Take register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_order_ff <= 1'b0;
         cfg_cols_ff  <= CFG_COLS_W'(1);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CHECK_ORDER: cfg_order_ff <= csr_wdata[0];
            CSR_COLS_IN_USE: cfg_cols_ff  <= csr_wdata[CFG_COLS_W-1:0];
            default: ;
         endcase
      end
   end

   // Saturate the compared column count to the stored columns
   assign ncmp = (cfg_cols_ff > CFG_COLS_W'(STORED_COLS)) ? CFG_COLS_W'(STORED_COLS)
                                                          : cfg_cols_ff;

   // Capture the accepted transaction
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_row_ff     <= req_tdata[ROW_W-1:0];
         item_restart_ff <= req_tuser;
         for (int c = 0; c < STORED_COLS; c++) begin
            item_keys_ff[c] <= req_tdata[ROW_W + c*KEY_W +: KEY_W];
         end
      end
   end

   assign item_word = {item_keys_ff, item_row_ff};

   // Read one nest per cycle while nests remain
   assign rd_en = cmd.scan && (ptr_ff < count_ff);

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[ptr_ff[AW-1:0]];
      end
      if (cmd.commit && (dec_kind_ff != KIND_FULL)) begin
         mem[dec_addr_ff] <= item_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff      <= '0;
         data_vld_ff <= 1'b0;
      end else if (cmd.load) begin
         ptr_ff      <= '0;
         data_vld_ff <= 1'b0;
      end else if (cmd.scan) begin
         data_vld_ff <= rd_en;
         if (rd_en) begin
            ptr_ff <= ptr_ff + CW'(1);
         end
      end else if (cmd.decide) begin
         data_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         tag_ff <= ptr_ff[AW-1:0];
      end
   end

   // Compare the returned nest against the item
   always_comb begin
      fit = !cfg_order_ff || (item_row_ff >= rd_data_ff[ROW_W-1:0]);
      for (int c = 0; c < STORED_COLS; c++) begin
         if (CFG_COLS_W'(c) < ncmp) begin
            if ($signed(item_keys_ff[c]) < $signed(rd_data_ff[ROW_W + c*KEY_W +: KEY_W])) begin
               fit = 1'b0;
            end
         end
      end
   end

   assign sts.quick     = item_restart_ff || (count_ff == '0);
   assign sts.hit       = data_vld_ff && fit;
   assign sts.exhausted = !data_vld_ff && (ptr_ff >= count_ff);
   assign sts.rsp_free  = !rsp_valid_ff || rsp_tready;

   // Pick where the item goes
   always_comb begin
      dec_kind_in = KIND_FULL;
      dec_addr_in = '0;
      priority if (sts.quick) begin
         dec_kind_in = KIND_RESTART;
      end else if (sts.hit) begin
         dec_kind_in = KIND_HIT;
         dec_addr_in = tag_ff;
      end else if (count_ff < CW'(MAX_NESTS)) begin
         dec_kind_in = KIND_APPEND;
         dec_addr_in = count_ff[AW-1:0];
      end else begin
         dec_kind_in = KIND_FULL;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         dec_kind_ff <= dec_kind_in;
         dec_addr_ff <= dec_addr_in;
      end
   end

   // Update the nest count on commit
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.commit) begin
         unique case (dec_kind_ff)
            KIND_RESTART: count_ff <= CW'(1);
            KIND_APPEND:  count_ff <= count_ff + CW'(1);
            KIND_HIT, KIND_FULL: ;
            default: ;
         endcase
      end
   end

   // Result register: load on commit, drop when taken
   assign id_wide = IW'(dec_addr_ff) + IW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_id_ff     <= (dec_kind_ff == KIND_FULL) ? '0 : id_wide[NEST_ID_W-1:0];
         rsp_opened_ff <= (dec_kind_ff == KIND_RESTART) || (dec_kind_ff == KIND_APPEND);
         rsp_full_ff   <= (dec_kind_ff == KIND_FULL);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_id_ff);
   assign rsp_tuser  = {rsp_full_ff, rsp_opened_ff};

   // The table never holds more nests than it has rows
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_NESTS))
      else $error("nest count beyond table size");

   // A compared entry always lies inside the nests in use
   a_tag_in_use: assert property (@(posedge clock) disable iff (reset)
      data_vld_ff |-> (CW'(tag_ff) < count_ff))
      else $error("compared entry outside nests in use");

   // Any committed item other than an overflow leaves the table non-empty
   a_commit_fills: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && (dec_kind_ff != KIND_FULL)) |=> (count_ff != '0))
      else $error("table empty after placing an item");

   // An overflow result carries id zero and opens nothing
   a_full_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_full_ff) |-> ((rsp_id_ff == '0) && !rsp_opened_ff))
      else $error("overflow result with a nest id");

endmodule

// ----- design/nested_group_assigner.sv -----
// Top level of the nested group assigner: joins the controller and the datapath.
// Depends on ngrp_pkg, ngrp_ctrl and ngrp_dpath.
//
//   channel  direction  handshake             payload
//   req      in         req_tvalid/tready     tdata: row_index, key_a..key_d; tuser: restart
//   rsp      out        rsp_tvalid/tready     tdata: nest_id; tuser: opened_nest, table_full
//   csr      in         csr_valid/ready       csr_index, csr_wdata
//
// An item is compared against the nests in use until one fits or all are compared,
// and a restart or an empty table skips the scan; the nest table memory reads one
// nest per cycle on its single read port while scanning.
// Reset clears control, the nest count and the registers; the table needs no clearing.
// A result waiting on rsp_tready does not block acceptance of the next item, only
// its commit.
module nested_group_assigner import ngrp_pkg::*; #(
   parameter int MAX_NESTS = 64,
   parameter int KEY_COLS  = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // row_index[30:0], key_a, key_b, key_c, key_d, pad
   input  logic                   req_tuser,   // restart
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // nest_id[6:0], pad
   output logic [RSP_TUSER_W-1:0] rsp_tuser,   // opened_nest, table_full
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   ngrp_cmd_type cmd;
   ngrp_sts_type sts;

   // Registers are always writable
   assign csr_ready = 1'b1;

   ngrp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ngrp_dpath #(
      .MAX_NESTS (MAX_NESTS),
      .KEY_COLS  (KEY_COLS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

endmodule
